### src/tmgp_pkg.sv
package tmgp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SQX,
        ST_SQY,
        ST_SQSUM,
        ST_ROOT,
        ST_DSQ,
        ST_SLP,
        ST_RCP,
        ST_FAC,
        ST_SCX,
        ST_SCY,
        ST_FIN
    } state_t;

    localparam logic [2:0] MODE_POINTER  = 3'd0;
    localparam logic [2:0] MODE_NAV      = 3'd1;
    localparam logic [2:0] MODE_OVERVIEW = 3'd2;
    localparam logic [2:0] MODE_SCROLL   = 3'd3;
    localparam logic [2:0] MODE_MEDIA    = 3'd4;
    localparam logic [2:0] MODE_ZOOM     = 3'd5;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_NEXT      = 3'd1;
    localparam logic [2:0] ACT_PREV      = 3'd2;
    localparam logic [2:0] ACT_OVW_FWD   = 3'd3;
    localparam logic [2:0] ACT_OVW_BACK  = 3'd4;
    localparam logic [2:0] ACT_VOL_DOWN  = 3'd5;
    localparam logic [2:0] ACT_VOL_UP    = 3'd6;

    localparam logic [1:0] SIDE_NONE     = 2'd0;
    localparam logic [1:0] SIDE_BRT_UP   = 2'd1;
    localparam logic [1:0] SIDE_BRT_DOWN = 2'd2;

    localparam logic [2:0] REG_ACCEL_OFFSET  = 3'd0;
    localparam logic [2:0] REG_ACCEL_SLOPE   = 3'd1;
    localparam logic [2:0] REG_ACCEL_LIMIT   = 3'd2;
    localparam logic [2:0] REG_NAV_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_NAV_COOLDOWN  = 3'd4;
    localparam logic [2:0] REG_MEDIA_THRESH  = 3'd5;
    localparam logic [2:0] REG_SCROLL_SENS   = 3'd6;
    localparam logic [2:0] REG_OVERFLOW_LIM  = 3'd7;

    // ceil(2^26 / 125): exact quotient for dividends below 2^19
    localparam logic [19:0] RCP_K     = 20'd536871;
    localparam int          RCP_SHIFT = 26;
    // 3840 * 125: at or above this the factor is past any legal limit
    localparam logic [51:0] CAP_LEVEL = 52'd480000;
    localparam logic [11:0] UNITY     = 12'd256;

endpackage

### src/tmgp_if.sv
interface tmgp_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  mode;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic        [15:0] now_ms;

    modport source (output valid, mode, dx, dy, now_ms, input ready);
    modport sink   (input valid, mode, dx, dy, now_ms, output ready);
endinterface

interface tmgp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [7:0]  out_v;
    logic signed [7:0]  out_h;
    logic        [2:0]  action_main;
    logic        [1:0]  action_side;

    modport source (output valid, out_x, out_y, out_v, out_h, action_main, action_side,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_v, out_h, action_main, action_side,
                    output ready);
endinterface

### src/trackball_motion_gesture_processor.sv
// Trackball motion and gesture processor.
// motion: one request per sensor poll (mode, dx, dy, now_ms), valid/ready.
// report: exactly one result per request (pointer motion, wheel counts and
//   gesture actions), valid/ready, held in an output register.
// cfg_we/cfg_index/cfg_data write the eight tuning registers; write only
//   while no request is in flight.
// One request is processed at a time. Pointer mode (and undefined modes) runs
//   two squaring passes, a 16-step square root, then up to five passes through
//   the one shared multiplier, skipping the slope and reciprocal passes when
//   the speed is at or below the offset; scroll mode makes two multiplier
//   passes; all other modes go straight to the result. The next request can be
//   taken in the cycle report.valid rises if report.ready is high then.
// motion.ready is high only in idle while the output register is free or
//   being taken that cycle, so a stalled receiver stops new requests after
//   one finished result waits.
// Reset puts every tuning register at its default and clears all
// accumulators, the gesture timestamp and the previous mode (pointer).
module trackball_motion_gesture_processor #(
    parameter int ACCUM_BITS  = 16,
    parameter int ROLLOVER_MS = 60000
) (
    input  logic        clk,
    input  logic        rst_n,
    tmgp_in_if.sink     motion,
    tmgp_out_if.source  report,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int WW = ((ACCUM_BITS > 16) ? ACCUM_BITS : 16) + 2;
    localparam logic [15:0] ROLL = 16'(ROLLOVER_MS);
    localparam logic signed [WW-1:0] ACC_MAX = WW'((longint'(1) <<< (ACCUM_BITS - 1)) - 1);
    localparam logic signed [WW-1:0] ACC_MIN = -ACC_MAX - WW'(1);
    localparam logic [11:0] UNITY_W = tmgp_pkg::UNITY;

    function automatic logic signed [ACCUM_BITS-1:0] acc_sat(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] c;
        c = (v > ACC_MAX) ? ACC_MAX : ((v < ACC_MIN) ? ACC_MIN : v);
        return c[ACCUM_BITS-1:0];
    endfunction

    function automatic logic acc_over(input logic signed [ACCUM_BITS-1:0] a,
                                      input logic [14:0] lim);
        logic signed [WW-1:0] w;
        w = WW'(a);
        if (w < 0)
        begin
            w = -w;
        end
        return w > $signed(WW'({1'b0, lim}));
    endfunction

    function automatic logic signed [15:0] scale_sat(input logic neg, input logic [31:0] p);
        logic [23:0] m;
        m = p[31:8];
        if (neg)
        begin
            return (m > 24'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, m}));
        end
        return (m > 24'd32767) ? 16'sd32767 : 16'(m);
    endfunction

    function automatic logic signed [7:0] clamp127(input logic signed [25:0] v);
        return (v > 26'sd127) ? 8'sd127 : ((v < -26'sd127) ? -8'sd127 : v[7:0]);
    endfunction

    function automatic logic signed [23:0] frac_sat(input logic signed [24:0] v);
        return (v > 25'sd8388607) ? 24'sd8388607 :
               ((v < -25'sd8388608) ? -24'sd8388608 : v[23:0]);
    endfunction

    // configuration
    logic [9:0]  offset_reg;
    logic [11:0] slope_reg;
    logic [11:0] limit_reg;
    logic [14:0] nav_thr_reg;
    logic [15:0] cooldown_reg;
    logic [14:0] media_thr_reg;
    logic [7:0]  sens_reg;
    logic [14:0] ovf_lim_reg;

    // control and state
    tmgp_pkg::state_t state_reg, state_next;
    logic signed [ACCUM_BITS-1:0] nax_reg, nax_next, nay_reg, nay_next;
    logic signed [ACCUM_BITS-1:0] max_reg, max_next, may_reg, may_next;
    logic signed [23:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [15:0] last_reg, last_next;
    logic [2:0]  prev_mode_reg, prev_mode_next;
    logic        ovalid_reg, ovalid_next;

    // datapath
    logic [2:0]  mode_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [15:0] now_reg;
    logic [31:0] rem_reg, rem_next, root_reg, root_next, bit_reg, bit_next;
    logic [51:0] prod_reg;
    logic [31:0] px_reg, px_next;
    logic [11:0] f_reg, f_next;
    logic        capped_reg, capped_next;
    logic signed [15:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [7:0]  ov_reg, ov_next, oh_reg, oh_next;
    logic [2:0]  am_reg, am_next;
    logic [1:0]  as_reg, as_next;

    logic [31:0] mul_a;
    logic [19:0] mul_b;
    logic        accept, is_ptr;
    logic [15:0] adx, ady, dval;
    logic [32:0] trial;
    logic [51:0] pval;
    logic [12:0] fsum;
    logic [15:0] elapsed;
    logic        cool;
    logic signed [WW-1:0] nthr, mthr, ax, ay;
    logic signed [23:0] spx, spy, sfx, sfy;
    logic signed [25:0] vq, hq;
    logic signed [7:0]  vv, hh;

    assign accept = motion.valid && motion.ready;
    assign motion.ready = (state_reg == tmgp_pkg::ST_IDLE) && (!ovalid_reg || report.ready);
    assign is_ptr = !((mode_reg == tmgp_pkg::MODE_NAV) || (mode_reg == tmgp_pkg::MODE_OVERVIEW)
                   || (mode_reg == tmgp_pkg::MODE_SCROLL) || (mode_reg == tmgp_pkg::MODE_MEDIA)
                   || (mode_reg == tmgp_pkg::MODE_ZOOM));
    assign adx = dx_reg[15] ? 16'(-dx_reg) : dx_reg;
    assign ady = dy_reg[15] ? 16'(-dy_reg) : dy_reg;
    assign dval = 16'(root_reg - 32'(offset_reg));
    assign trial = 33'(root_reg) + 33'(bit_reg);
    assign pval = {prod_reg[50:0], 1'b0};
    assign fsum = 13'(UNITY_W) + 13'(prod_reg[tmgp_pkg::RCP_SHIFT+11:tmgp_pkg::RCP_SHIFT]);
    assign elapsed = now_reg - last_reg;
    assign cool = elapsed > cooldown_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = 32'(adx);
        mul_b = 20'(adx);
        case (state_reg)
            tmgp_pkg::ST_SQX:
            begin
                mul_a = 32'(adx);
                mul_b = 20'(adx);
            end
            tmgp_pkg::ST_SQY:
            begin
                mul_a = 32'(ady);
                mul_b = 20'(ady);
            end
            tmgp_pkg::ST_DSQ:
            begin
                mul_a = 32'(dval);
                mul_b = 20'(dval);
            end
            tmgp_pkg::ST_SLP:
            begin
                mul_a = prod_reg[31:0];
                mul_b = 20'(slope_reg);
            end
            tmgp_pkg::ST_RCP:
            begin
                mul_a = 32'(pval[18:0]);
                mul_b = tmgp_pkg::RCP_K;
            end
            tmgp_pkg::ST_SCX:
            begin
                mul_a = 32'(adx);
                mul_b = is_ptr ? 20'(f_reg) : 20'(sens_reg);
            end
            tmgp_pkg::ST_SCY:
            begin
                mul_a = 32'(ady);
                mul_b = is_ptr ? 20'(f_reg) : 20'(sens_reg);
            end
            default:
            begin
                mul_a = 32'(adx);
                mul_b = 20'(adx);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        nax_next = nax_reg;
        nay_next = nay_reg;
        max_next = max_reg;
        may_next = may_reg;
        fx_next = fx_reg;
        fy_next = fy_reg;
        last_next = last_reg;
        prev_mode_next = prev_mode_reg;
        ovalid_next = ovalid_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        bit_next = bit_reg;
        px_next = px_reg;
        f_next = f_reg;
        capped_next = capped_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        ov_next = ov_reg;
        oh_next = oh_reg;
        am_next = am_reg;
        as_next = as_reg;

        nthr = $signed(WW'({1'b0, nav_thr_reg}));
        mthr = $signed(WW'({1'b0, media_thr_reg}));
        ax = '0;
        ay = '0;
        spx = dx_reg[15] ? 24'(-$signed({1'b0, px_reg[22:0]})) : 24'(px_reg[22:0]);
        spy = dy_reg[15] ? 24'(-$signed({1'b0, prod_reg[22:0]})) : 24'(prod_reg[22:0]);
        sfx = frac_sat(25'(fx_reg) + 25'(spx));
        sfy = frac_sat(25'(fy_reg) + 25'(spy));
        vq = (-26'(sfy)) / 26'sd256;
        hq = 26'(sfx) / 26'sd256;
        vv = clamp127(vq);
        hh = clamp127(hq);

        if (report.valid && report.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            tmgp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tmgp_pkg::ST_START;
                end
            end
            tmgp_pkg::ST_START:
            begin
                if (acc_over(nax_reg, ovf_lim_reg)) nax_next = '0;
                if (acc_over(nay_reg, ovf_lim_reg)) nay_next = '0;
                if (acc_over(max_reg, ovf_lim_reg)) max_next = '0;
                if (acc_over(may_reg, ovf_lim_reg)) may_next = '0;
                if (mode_reg != prev_mode_reg)
                begin
                    if (mode_reg == tmgp_pkg::MODE_NAV)
                    begin
                        nax_next = '0;
                        nay_next = '0;
                    end
                    else if (mode_reg == tmgp_pkg::MODE_OVERVIEW)
                    begin
                        nay_next = '0;
                    end
                    else if (mode_reg == tmgp_pkg::MODE_MEDIA)
                    begin
                        max_next = '0;
                        may_next = '0;
                    end
                end
                prev_mode_next = mode_reg;
                if (elapsed > ROLL)
                begin
                    last_next = now_reg;
                end
                if (is_ptr)
                    state_next = tmgp_pkg::ST_SQX;
                else if (mode_reg == tmgp_pkg::MODE_SCROLL)
                    state_next = tmgp_pkg::ST_SCX;
                else
                    state_next = tmgp_pkg::ST_FIN;
            end
            tmgp_pkg::ST_SQX:
            begin
                state_next = tmgp_pkg::ST_SQY;
            end
            tmgp_pkg::ST_SQY:
            begin
                rem_next = prod_reg[31:0];
                state_next = tmgp_pkg::ST_SQSUM;
            end
            tmgp_pkg::ST_SQSUM:
            begin
                rem_next = rem_reg + prod_reg[31:0];
                root_next = '0;
                bit_next = 32'h4000_0000;
                state_next = tmgp_pkg::ST_ROOT;
            end
            tmgp_pkg::ST_ROOT:
            begin
                if (33'(rem_reg) >= trial)
                begin
                    rem_next = rem_reg - trial[31:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = tmgp_pkg::ST_DSQ;
                end
            end
            tmgp_pkg::ST_DSQ:
            begin
                if (root_reg > 32'(offset_reg))
                begin
                    state_next = tmgp_pkg::ST_SLP;
                end
                else
                begin
                    f_next = tmgp_pkg::UNITY;
                    state_next = tmgp_pkg::ST_SCX;
                end
            end
            tmgp_pkg::ST_SLP:
            begin
                state_next = tmgp_pkg::ST_RCP;
            end
            tmgp_pkg::ST_RCP:
            begin
                capped_next = (limit_reg < tmgp_pkg::UNITY) || (pval >= tmgp_pkg::CAP_LEVEL);
                state_next = tmgp_pkg::ST_FAC;
            end
            tmgp_pkg::ST_FAC:
            begin
                if (capped_reg || (fsum > 13'(limit_reg)))
                    f_next = limit_reg;
                else
                    f_next = fsum[11:0];
                state_next = tmgp_pkg::ST_SCX;
            end
            tmgp_pkg::ST_SCX:
            begin
                state_next = tmgp_pkg::ST_SCY;
            end
            tmgp_pkg::ST_SCY:
            begin
                px_next = prod_reg[31:0];
                state_next = tmgp_pkg::ST_FIN;
            end
            tmgp_pkg::ST_FIN:
            begin
                ox_next = '0;
                oy_next = '0;
                ov_next = '0;
                oh_next = '0;
                am_next = tmgp_pkg::ACT_NONE;
                as_next = tmgp_pkg::SIDE_NONE;
                case (mode_reg)
                    tmgp_pkg::MODE_NAV:
                    begin
                        ax = WW'(acc_sat(WW'(nax_reg) + WW'(dx_reg)));
                        ay = WW'(acc_sat(WW'(nay_reg) + WW'(dy_reg)));
                        nax_next = ax[ACCUM_BITS-1:0];
                        nay_next = ay[ACCUM_BITS-1:0];
                        if (cool && ((ax > nthr) || (ax < -nthr)))
                        begin
                            am_next = (ax > nthr) ? tmgp_pkg::ACT_NEXT : tmgp_pkg::ACT_PREV;
                            last_next = now_reg;
                            nax_next = '0;
                            nay_next = '0;
                        end
                    end
                    tmgp_pkg::MODE_OVERVIEW:
                    begin
                        ay = WW'(acc_sat(WW'(nay_reg) + WW'(dy_reg)));
                        nay_next = ay[ACCUM_BITS-1:0];
                        if (cool && ((ay > nthr) || (ay < -nthr)))
                        begin
                            am_next = (ay < -nthr) ? tmgp_pkg::ACT_OVW_FWD
                                                   : tmgp_pkg::ACT_OVW_BACK;
                            last_next = now_reg;
                            nay_next = '0;
                        end
                    end
                    tmgp_pkg::MODE_SCROLL:
                    begin
                        ov_next = vv;
                        oh_next = hh;
                        fy_next = 24'(26'(sfy) + (26'(vv) <<< 8));
                        fx_next = 24'(26'(sfx) - (26'(hh) <<< 8));
                    end
                    tmgp_pkg::MODE_MEDIA:
                    begin
                        ax = WW'(acc_sat(WW'(max_reg) + WW'(dx_reg)));
                        ay = WW'(acc_sat(WW'(may_reg) + WW'(dy_reg)));
                        max_next = ax[ACCUM_BITS-1:0];
                        may_next = ay[ACCUM_BITS-1:0];
                        if (ay > mthr)
                        begin
                            am_next = tmgp_pkg::ACT_VOL_DOWN;
                            may_next = '0;
                        end
                        else if (ay < -mthr)
                        begin
                            am_next = tmgp_pkg::ACT_VOL_UP;
                            may_next = '0;
                        end
                        if (ax > mthr)
                        begin
                            as_next = tmgp_pkg::SIDE_BRT_UP;
                            max_next = '0;
                        end
                        else if (ax < -mthr)
                        begin
                            as_next = tmgp_pkg::SIDE_BRT_DOWN;
                            max_next = '0;
                        end
                    end
                    tmgp_pkg::MODE_ZOOM:
                    begin
                        ov_next = clamp127(-26'(dy_reg));
                    end
                    default:
                    begin
                        ox_next = scale_sat(dx_reg[15], px_reg);
                        oy_next = scale_sat(dy_reg[15], prod_reg[31:0]);
                    end
                endcase
                ovalid_next = 1'b1;
                state_next = tmgp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tmgp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmgp_pkg::ST_IDLE;
            nax_reg <= '0;
            nay_reg <= '0;
            max_reg <= '0;
            may_reg <= '0;
            fx_reg <= '0;
            fy_reg <= '0;
            last_reg <= '0;
            prev_mode_reg <= tmgp_pkg::MODE_POINTER;
            ovalid_reg <= 1'b0;
            offset_reg <= 10'd5;
            slope_reg <= 12'd160;
            limit_reg <= 12'd512;
            nav_thr_reg <= 15'd100;
            cooldown_reg <= 16'd300;
            media_thr_reg <= 15'd50;
            sens_reg <= 8'd26;
            ovf_lim_reg <= 15'd30000;
        end
        else
        begin
            state_reg <= state_next;
            nax_reg <= nax_next;
            nay_reg <= nay_next;
            max_reg <= max_next;
            may_reg <= may_next;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            last_reg <= last_next;
            prev_mode_reg <= prev_mode_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tmgp_pkg::REG_ACCEL_OFFSET:  offset_reg <= cfg_data[9:0];
                    tmgp_pkg::REG_ACCEL_SLOPE:   slope_reg <= cfg_data[11:0];
                    tmgp_pkg::REG_ACCEL_LIMIT:   limit_reg <= cfg_data[11:0];
                    tmgp_pkg::REG_NAV_THRESHOLD: nav_thr_reg <= cfg_data[14:0];
                    tmgp_pkg::REG_NAV_COOLDOWN:  cooldown_reg <= cfg_data;
                    tmgp_pkg::REG_MEDIA_THRESH:  media_thr_reg <= cfg_data[14:0];
                    tmgp_pkg::REG_SCROLL_SENS:   sens_reg <= cfg_data[7:0];
                    tmgp_pkg::REG_OVERFLOW_LIM:  ovf_lim_reg <= cfg_data[14:0];
                    default:                     ovf_lim_reg <= ovf_lim_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= motion.mode;
            dx_reg <= motion.dx;
            dy_reg <= motion.dy;
            now_reg <= motion.now_ms;
        end
        prod_reg <= 52'(mul_a) * 52'(mul_b);
        rem_reg <= rem_next;
        root_reg <= root_next;
        bit_reg <= bit_next;
        px_reg <= px_next;
        f_reg <= f_next;
        capped_reg <= capped_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        ov_reg <= ov_next;
        oh_reg <= oh_next;
        am_reg <= am_next;
        as_reg <= as_next;
    end

    assign report.valid = ovalid_reg;
    assign report.out_x = ox_reg;
    assign report.out_y = oy_reg;
    assign report.out_v = ov_reg;
    assign report.out_h = oh_reg;
    assign report.action_main = am_reg;
    assign report.action_side = as_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        motion.ready |-> (state_reg == tmgp_pkg::ST_IDLE))
        else $error("request taken while busy");

    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmgp_pkg::ST_FIN) |-> !ovalid_reg)
        else $error("result would overwrite a pending result");

    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmgp_pkg::ST_FIN) |=> ovalid_reg)
        else $error("finished request produced no result");

    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmgp_pkg::ST_ROOT) |-> $onehot(bit_reg))
        else $error("square root step bit lost");

endmodule
